/* rtl/ctb_pkg.sv */
// Shared types and constants for the callout timer bank.
// Used by ctb_ctrl, ctb_datapath and callout_timer_bank_top; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ctb_pkg;

    // Bank geometry
    localparam int CHANNELS  = 8;
    localparam int CH_W      = 3;
    localparam int MASK_W    = 8;
    localparam int OP_W      = 2;
    localparam int COUNT_W   = 31;
    localparam int REMAIN_W  = 32;

    localparam logic [CH_W-1:0]     LAST_CH   = CH_W'(CHANNELS - 1);
    localparam logic [REMAIN_W-1:0] IDLE_MARK = '1;

    // Operation codes
    localparam logic [OP_W-1:0] OP_ARM     = 2'd0;
    localparam logic [OP_W-1:0] OP_TICK    = 2'd1;
    localparam logic [OP_W-1:0] OP_SERVICE = 2'd2;

    // Arm status codes
    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_DISABLED = 1'b1;

    // Controller to datapath
    typedef struct packed {
        logic            load;       // latch input beat, clear scratch
        logic            arm;        // write armed count, record status
        logic            tick_step;  // count down channel idx
        logic            svc_step;   // check channel idx for expiry
        logic            finish;     // push the closing result beat
        logic [CH_W-1:0] idx;
    } ctb_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            out_free;   // output register can take a beat
    } ctb_stat_t;

endpackage

`default_nettype wire

/* rtl/ctb_datapath.sv */
// Datapath of the callout timer bank: count registers, enable mask, walk
// scratch and the output register. Depends on ctb_pkg; driven by ctb_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module ctb_datapath (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire ctb_pkg::ctb_cmd_t      cmd,
    output ctb_pkg::ctb_stat_t          stat,
    // input beat payload
    input  wire logic [ctb_pkg::OP_W-1:0]    op,
    input  wire logic [ctb_pkg::CH_W-1:0]    channel,
    input  wire logic [ctb_pkg::COUNT_W-1:0] count_value,
    // configuration
    input  wire logic                         cfg_valid,
    input  wire logic [ctb_pkg::MASK_W-1:0]   cfg_data,
    // result channel
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic                   status,
    output logic                   expiry_event,
    output logic                   fire_valid,
    output logic [ctb_pkg::CH_W-1:0] fire_channel,
    output logic                   last
);
    import ctb_pkg::*;

    logic [REMAIN_W-1:0] remain_reg [CHANNELS];
    logic [MASK_W-1:0]   mask_reg;

    logic [OP_W-1:0]     op_reg;
    logic [CH_W-1:0]     ch_reg;
    logic [COUNT_W-1:0]  cnt_reg;
    logic                arm_st_reg;
    logic                ev_reg;
    logic                pend_reg;
    logic [CH_W-1:0]     pend_ch_reg;

    logic                out_valid_reg;
    logic                status_reg;
    logic                event_reg;
    logic                fv_reg;
    logic [CH_W-1:0]     fch_reg;
    logic                last_reg;

    logic [REMAIN_W-1:0] cur;
    logic                cur_en;
    logic                arm_en;
    logic                tick_hit;
    logic                fire_hit;
    logic                out_free;
    logic                push;
    logic                push_st;
    logic                push_ev;
    logic                push_fv;
    logic [CH_W-1:0]     push_ch;
    logic                push_last;

    // Channel under the walk
    assign cur      = remain_reg[cmd.idx];
    assign cur_en   = mask_reg[cmd.idx];
    assign arm_en   = mask_reg[ch_reg];
    assign tick_hit = cur_en && (cur != '0) && !cur[REMAIN_W-1];
    assign fire_hit = cur_en && (cur == '0);
    assign out_free = !out_valid_reg || out_ready;

    assign stat.op       = op_reg;
    assign stat.out_free = out_free;

    // Result beat selection
    always_comb
    begin
        push      = 1'b0;
        push_st   = 1'b0;
        push_ev   = 1'b0;
        push_fv   = 1'b0;
        push_ch   = '0;
        push_last = 1'b1;
        if (cmd.svc_step && fire_hit && pend_reg)
        begin
            // an earlier fire is known not to be the final one
            push      = 1'b1;
            push_fv   = 1'b1;
            push_ch   = pend_ch_reg;
            push_last = 1'b0;
        end
        else if (cmd.finish)
        begin
            push = 1'b1;
            case (op_reg)
                OP_ARM:     push_st = arm_st_reg;
                OP_TICK:    push_ev = ev_reg;
                OP_SERVICE:
                begin
                    push_fv = pend_reg;
                    push_ch = pend_reg ? pend_ch_reg : '0;
                end
                default:    push_st = 1'b0;
            endcase
        end
    end

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mask_reg <= '0;
        else if (cfg_valid)
            mask_reg <= cfg_data;
    end

    // Remaining counts: one write per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
                remain_reg[i] <= IDLE_MARK;
        end
        else if (cmd.arm && arm_en)
            remain_reg[ch_reg] <= {1'b0, cnt_reg};
        else if (cmd.tick_step && tick_hit)
            remain_reg[cmd.idx] <= cur - 1'b1;
        else if (cmd.svc_step && fire_hit)
            remain_reg[cmd.idx] <= IDLE_MARK;
    end

    // Input latch and walk scratch
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ev_reg   <= 1'b0;
            pend_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            ev_reg   <= 1'b0;
            pend_reg <= 1'b0;
        end
        else
        begin
            if (cmd.tick_step && tick_hit && (cur == REMAIN_W'(1)))
                ev_reg <= 1'b1;
            if (cmd.svc_step && fire_hit)
                pend_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= op;
            ch_reg  <= channel;
            cnt_reg <= count_value;
        end
        if (cmd.arm)
            arm_st_reg <= arm_en ? STATUS_OK : STATUS_DISABLED;
        if (cmd.svc_step && fire_hit)
            pend_ch_reg <= cmd.idx;
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (push)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            status_reg <= push_st;
            event_reg  <= push_ev;
            fv_reg     <= push_fv;
            fch_reg    <= push_ch;
            last_reg   <= push_last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign expiry_event = event_reg;
    assign fire_valid   = fv_reg;
    assign fire_channel = fch_reg;
    assign last         = last_reg;

endmodule

`default_nettype wire

/* rtl/ctb_ctrl.sv */
// Controller of the callout timer bank: sequences one operation at a time
// and walks the channels. Depends on ctb_pkg; drives ctb_datapath.
`timescale 1ns / 1ps
`default_nettype none

module ctb_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire ctb_pkg::ctb_stat_t stat,
    output ctb_pkg::ctb_cmd_t       cmd
);
    import ctb_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_TICK,
        S_SVC,
        S_FINISH
    } state_t;

    state_t          state_reg, state_next;
    logic [CH_W-1:0] idx_reg, idx_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        cmd        = '0;
        cmd.idx    = idx_reg;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                idx_next = LAST_CH;
                case (stat.op)
                    OP_ARM:
                    begin
                        cmd.arm    = 1'b1;
                        state_next = S_FINISH;
                    end
                    OP_TICK:    state_next = S_TICK;
                    OP_SERVICE: state_next = S_SVC;
                    default:    state_next = S_FINISH;
                endcase
            end
            S_TICK:
            begin
                cmd.tick_step = 1'b1;
                idx_next      = idx_reg - 1'b1;
                if (idx_reg == '0)
                    state_next = S_FINISH;
            end
            S_SVC:
            begin
                // a step may push a beat, so wait for room
                if (stat.out_free)
                begin
                    cmd.svc_step = 1'b1;
                    idx_next     = idx_reg - 1'b1;
                    if (idx_reg == '0)
                        state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/callout_timer_bank_top.sv */
// Sequence: an accepted beat is latched and dispatched on its op; arm and the
// unused op go on to the closing beat, while tick and service first walk the 8
// count registers from the last channel down, one channel per cycle, a
// service step waiting while the output is stalled. The closing beat also
// waits for room in the output register. Throughput: one beat at a time; a
// new beat is taken once the last result sits in the output register.
// Reset: asynchronous, active low; all channels idle, enable mask cleared.
// Depends on ctb_pkg, ctb_ctrl and ctb_datapath.
`timescale 1ns / 1ps
`default_nettype none

module callout_timer_bank_top (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [ctb_pkg::OP_W-1:0]      op,
    input  wire logic [ctb_pkg::CH_W-1:0]      channel,
    input  wire logic [ctb_pkg::COUNT_W-1:0]   count_value,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [ctb_pkg::MASK_W-1:0]    cfg_data,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic                               status,
    output logic                               expiry_event,
    output logic                               fire_valid,
    output logic [ctb_pkg::CH_W-1:0]           fire_channel,
    output logic                               last
);
    import ctb_pkg::*;

    ctb_cmd_t  cmd;
    ctb_stat_t stat;

    // Mask writes are always taken
    assign cfg_ready = 1'b1;

    ctb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ctb_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .op           (op),
        .channel      (channel),
        .count_value  (count_value),
        .cfg_valid    (cfg_valid),
        .cfg_data     (cfg_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .expiry_event (expiry_event),
        .fire_valid   (fire_valid),
        .fire_channel (fire_channel),
        .last         (last)
    );

endmodule

`default_nettype wire
